// ===== rtl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the line position centroid block.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // window bounds and the weight of one sensor step
  localparam int unsigned WIN_W       = 3;
  localparam int unsigned WEIGHT_STEP = 1000;

  // configuration port
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned MIN_TOT_W   = 16;
  localparam logic [MIN_TOT_W-1:0] MIN_TOTAL_RESET = 16'd200;
  // word index of each register (paddr bit 2)
  localparam logic CFG_IDX_MIN_TOTAL = 1'b0;

  typedef enum logic {
    OP_CAL  = 1'b0,
    OP_MEAS = 1'b1
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LANE = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  // control from the sequencer to every lane
  typedef struct packed {
    logic load;   // capture a new sample
    logic calib;  // sample is a calibration sample
    logic calc;   // register the lane results
  } lane_ctl_t;

  // status of the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/lpc_ifs.sv =====
// ----------------------------------------------------------------------------
// lpc_ifs
// Request and result channels of the line position centroid block.
// ----------------------------------------------------------------------------
interface lpc_in_if #(
  parameter int unsigned NUM_SENSORS = 5,
  parameter int unsigned SAMPLE_BITS = 12
) ();
  import lpc_pkg::*;

  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [NUM_SENSORS*SAMPLE_BITS-1:0] raw;
  logic [WIN_W-1:0]                   window_start;
  logic [WIN_W-1:0]                   window_end;

  modport source (output valid, operation, raw, window_start, window_end, input ready);
  modport sink   (input valid, operation, raw, window_start, window_end, output ready);
endinterface

interface lpc_out_if #(
  parameter int unsigned NUM_SENSORS = 5,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned POS_W       = 12
) ();
  logic                                   valid;
  logic                                   ready;
  logic [POS_W-1:0]                       position;
  logic                                   line_found;
  logic [NUM_SENSORS*(SAMPLE_BITS+1)-1:0] cal;

  modport source (output valid, position, line_found, cal, input ready);
  modport sink   (input valid, position, line_found, cal, output ready);
endinterface

// ===== rtl/line_position_centroid.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid
// Reflectance line position: per-sensor minimum calibration, calibrated
// values and the weighted centroid of the signal inside a sensor window.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    operation, raw, window_start, window_end
//   out_o    out  valid / ready    position, line_found, cal
//   apb      in   psel / penable   min_total at byte address 0
//
// An accepted request passes the lane, sum, load, divide and done states; the
// restoring divider in the divide state yields one quotient bit a cycle.
// Requests are taken one at a time; the next one is accepted while a result
// still waits in the output register, and finishes once that register frees.
// Reset sets min_total to 200 and every stored minimum to all ones.
// ----------------------------------------------------------------------------
module line_position_centroid #(
  parameter int unsigned NUM_SENSORS = 5,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lpc_in_if.sink                        in_i,
  lpc_out_if.source                     out_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [lpc_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [lpc_pkg::APB_DW-1:0]    pwdata_i,
  output logic [lpc_pkg::APB_DW-1:0]    prdata_o,
  output logic                          pready_o
);
  import lpc_pkg::*;

  localparam int unsigned MAX_POS = WEIGHT_STEP * (NUM_SENSORS - 1);
  localparam int unsigned POS_W   = $clog2(MAX_POS + 1);
  localparam int unsigned TOT_W   = SAMPLE_BITS + $clog2(NUM_SENSORS);
  localparam int unsigned WS_W    = TOT_W + POS_W;
  localparam int unsigned CAL_W   = SAMPLE_BITS + 1;

  // configuration
  logic [MIN_TOT_W-1:0] min_total_q;
  logic                 cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_total_q <= MIN_TOTAL_RESET;
    end else if (cfg_wr && (paddr_i[2] == CFG_IDX_MIN_TOTAL)) begin
      min_total_q <= pwdata_i[MIN_TOT_W-1:0];
    end
  end

  assign prdata_o = (paddr_i[2] == CFG_IDX_MIN_TOTAL) ?
                    APB_DW'(min_total_q) : '0;

  // sequencer
  state_e    state_q, state_d;
  logic      accept;
  logic      out_free;
  lane_ctl_t lane_ctl;
  div_stat_t div_stat;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_o.valid || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept)        state_d = ST_LANE;
      ST_LANE:                    state_d = ST_SUM;
      ST_SUM:                     state_d = ST_LOAD;
      ST_LOAD:                    state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_DONE;
      ST_DONE: if (out_free)      state_d = ST_IDLE;
      default:                    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign lane_ctl.load  = accept;
  assign lane_ctl.calib = (op_e'(in_i.operation) == OP_CAL);
  assign lane_ctl.calc  = (state_q == ST_LANE);

  // lanes
  logic [NUM_SENSORS-1:0][CAL_W-1:0]         cal_w;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   d_w;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS+POS_W-1:0] wd_w;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lpc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .W_W         (POS_W),
      .LANE_IDX    (g)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (lane_ctl),
      .sample_i    (in_i.raw[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .win_start_i (in_i.window_start),
      .win_end_i   (in_i.window_end),
      .cal_o       (cal_w[g]),
      .d_o         (d_w[g]),
      .wd_o        (wd_w[g])
    );
  end

  // merge
  logic [TOT_W-1:0] total;
  logic [WS_W-1:0]  weighted;
  logic             found;

  lpc_merge #(
    .NUM_SENSORS (NUM_SENSORS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .W_W         (POS_W)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (state_q == ST_SUM),
    .min_total_i (min_total_q),
    .d_i         (d_w),
    .wd_i        (wd_w),
    .total_o     (total),
    .weighted_o  (weighted),
    .found_o     (found)
  );

  // divider
  logic [POS_W-1:0] quotient;

  lpc_div #(
    .TOT_W (TOT_W),
    .Q_W   (POS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LOAD),
    .dividend_i (weighted),
    .divisor_i  (total),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // output register
  logic                       out_valid_q;
  logic [POS_W-1:0]           pos_q;
  logic                       found_q;
  logic [NUM_SENSORS*CAL_W-1:0] cal_q;
  logic                       out_load;

  assign out_load = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q   <= found ? quotient : '0;
      found_q <= found;
      cal_q   <= cal_w;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.position   = pos_q;
  assign out_o.line_found = found_q;
  assign out_o.cal        = cal_q;

  // checks
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside the divide state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LANE))
    else $error("accepted request did not start the lanes");

  a_no_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.line_found) |-> (out_o.position == '0))
    else $error("position nonzero without a line");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.line_found) |-> (out_o.position <= POS_W'(MAX_POS)))
    else $error("position beyond the last sensor weight");

endmodule

// ===== rtl/lpc_lane.sv =====
// ----------------------------------------------------------------------------
// lpc_lane
// One sensor lane: stored minimum, calibrated value and weighted signal.
// ----------------------------------------------------------------------------
module lpc_lane #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned W_W         = 12,
  parameter int unsigned LANE_IDX    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpc_pkg::lane_ctl_t           ctl_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [lpc_pkg::WIN_W-1:0]    win_start_i,
  input  logic [lpc_pkg::WIN_W-1:0]    win_end_i,
  output logic [SAMPLE_BITS:0]         cal_o,
  output logic [SAMPLE_BITS-1:0]       d_o,
  output logic [SAMPLE_BITS+W_W-1:0]   wd_o
);
  import lpc_pkg::*;

  localparam logic [W_W-1:0]   WEIGHT = W_W'(WEIGHT_STEP * LANE_IDX);
  localparam logic [WIN_W-1:0] IDX    = WIN_W'(LANE_IDX);

  logic [SAMPLE_BITS-1:0]     min_q;
  logic [SAMPLE_BITS-1:0]     sample_q;
  logic                       in_win_q;
  logic [SAMPLE_BITS:0]       cal_q;
  logic [SAMPLE_BITS-1:0]     d_q;
  logic [SAMPLE_BITS+W_W-1:0] wd_q;
  logic [SAMPLE_BITS-1:0]     d_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
    end else if (ctl_i.load && ctl_i.calib && (sample_i < min_q)) begin
      min_q <= sample_i;
    end
  end

  // the window end needs no clamp: this lane's index is below the sensor count
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sample_q <= sample_i;
      in_win_q <= !ctl_i.calib && (win_start_i <= IDX) && (IDX < win_end_i);
    end
  end

  always_comb begin
    d_d = '0;
    if (in_win_q && (sample_q > min_q)) begin
      d_d = sample_q - min_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.calc) begin
      cal_q <= {1'b0, sample_q} - {1'b0, min_q};
      d_q   <= d_d;
      wd_q  <= (SAMPLE_BITS+W_W)'(d_d) * (SAMPLE_BITS+W_W)'(WEIGHT);
    end
  end

  assign cal_o = cal_q;
  assign d_o   = d_q;
  assign wd_o  = wd_q;

endmodule

// ===== rtl/lpc_merge.sv =====
// ----------------------------------------------------------------------------
// lpc_merge
// Sums the lane signals and weighted signals and decides if a line is found.
// ----------------------------------------------------------------------------
module lpc_merge #(
  parameter  int unsigned NUM_SENSORS = 5,
  parameter  int unsigned SAMPLE_BITS = 12,
  parameter  int unsigned W_W         = 12,
  localparam int unsigned TOT_W       = SAMPLE_BITS + $clog2(NUM_SENSORS),
  localparam int unsigned WS_W        = TOT_W + W_W
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic [lpc_pkg::MIN_TOT_W-1:0]               min_total_i,
  input  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]     d_i,
  input  logic [NUM_SENSORS-1:0][SAMPLE_BITS+W_W-1:0] wd_i,
  output logic [TOT_W-1:0]                            total_o,
  output logic [WS_W-1:0]                             weighted_o,
  output logic                                        found_o
);
  import lpc_pkg::*;

  localparam int unsigned CMP_W = (TOT_W > MIN_TOT_W) ? TOT_W : MIN_TOT_W;

  logic [TOT_W-1:0] tot_d, total_q;
  logic [WS_W-1:0]  ws_d, weighted_q;
  logic             found_d, found_q;

  always_comb begin
    tot_d = '0;
    ws_d  = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      tot_d = tot_d + TOT_W'(d_i[i]);
      ws_d  = ws_d + WS_W'(wd_i[i]);
    end
    // a zero total never counts, even with a zero threshold
    found_d = (tot_d != '0) && (CMP_W'(tot_d) >= CMP_W'(min_total_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (en_i) begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q    <= tot_d;
      weighted_q <= ws_d;
    end
  end

  assign total_o    = total_q;
  assign weighted_o = weighted_q;
  assign found_o    = found_q;

endmodule

// ===== rtl/lpc_div.sv =====
// ----------------------------------------------------------------------------
// lpc_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// Q_W bits, so the upper dividend bits start as the partial remainder.
// ----------------------------------------------------------------------------
module lpc_div #(
  parameter int unsigned TOT_W = 15,
  parameter int unsigned Q_W   = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TOT_W+Q_W-1:0]   dividend_i,
  input  logic [TOT_W-1:0]       divisor_i,
  output logic [Q_W-1:0]         quotient_o,
  output lpc_pkg::div_stat_t     stat_o
);
  import lpc_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [TOT_W:0]   rem_q;
  logic [Q_W-1:0]   quo_q;
  logic [TOT_W-1:0] div_q;
  logic [TOT_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[TOT_W-1:0], quo_q[Q_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(Q_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[TOT_W+Q_W-1:Q_W]};
      quo_q <= dividend_i[Q_W-1:0];
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      // shift in the next dividend bit, subtract where it fits
      rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// ===== verif/line_position_centroid_tb.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid_tb
// Self-checking bench for the line position centroid block. Calibration and
// measure requests are fed from a queue through a randomly idling driver. The
// bench keeps its own copy of the sensor minima and of min_total and predicts
// every result at the moment a request is accepted. A monitor with random
// stalls and one long hold-off compares each result field by field. Several
// min_total settings are loaded over the APB port between phases, and each
// write is read back.
// ----------------------------------------------------------------------------
module line_position_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam int unsigned NS       = 5;
  localparam int unsigned SB       = 12;
  localparam int unsigned SAMPLE_MAX = (1 << SB) - 1;
  localparam logic [PADDR_W-1:0] MIN_TOTAL_ADDR = {CFG_IDX_MIN_TOTAL, 2'b00};

  typedef struct packed {
    op_e                  op;
    logic [NS-1:0][SB-1:0] raw;
    logic [WIN_W-1:0]     wstart;
    logic [WIN_W-1:0]     wend;
  } sensor_sample_t;

  typedef struct packed {
    logic [11:0]           pos;
    logic                  found;
    logic [NS-1:0][SB:0]   cal;
  } line_reading_t;

  logic clk_i;
  logic rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [PADDR_W-1:0] paddr_i;
  logic [APB_DW-1:0]  pwdata_i;
  logic [APB_DW-1:0]  prdata_o;
  logic               pready_o;

  lpc_in_if  #(.NUM_SENSORS(NS), .SAMPLE_BITS(SB)) in_ch ();
  lpc_out_if #(.NUM_SENSORS(NS), .SAMPLE_BITS(SB)) out_ch ();

  line_position_centroid #(.NUM_SENSORS(NS), .SAMPLE_BITS(SB)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // predictor state
  logic [SB-1:0]        floor_q [NS];
  logic [MIN_TOT_W-1:0] thresh_q;

  sensor_sample_t sample_q [$];
  line_reading_t  reading_q [$];
  sensor_sample_t cur_sample;

  int n_errors, n_taken, n_results;
  int n_cal, n_meas, n_found, n_empty_win, n_negative;
  int gap_left, stall_left;
  bit in_burst, out_burst, hold_off;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // expected result of one accepted request; updates the stored minima
  function automatic line_reading_t locate_line(sensor_sample_t s);
    line_reading_t r;
    int unsigned total, weighted, diff, hi;
    r = '0;
    total = 0;
    weighted = 0;
    if (s.op == OP_CAL) begin
      n_cal++;
      for (int i = 0; i < NS; i++)
        if (s.raw[i] < floor_q[i]) floor_q[i] = s.raw[i];
    end else begin
      n_meas++;
    end
    for (int i = 0; i < NS; i++) begin
      r.cal[i] = {1'b0, s.raw[i]} - {1'b0, floor_q[i]};
      if (s.raw[i] < floor_q[i]) n_negative++;
    end
    if (s.op == OP_MEAS) begin
      hi = (s.wend > NS) ? NS : s.wend;
      if (s.wstart >= hi) n_empty_win++;
      for (int i = s.wstart; i < hi; i++) begin
        if (s.raw[i] > floor_q[i]) begin
          diff = s.raw[i] - floor_q[i];
          total += diff;
          weighted += diff * WEIGHT_STEP * i;
        end
      end
      if (total != 0 && total >= thresh_q) begin
        r.found = 1'b1;
        r.pos = 12'(weighted / total);
        n_found++;
      end
    end
    return r;
  endfunction

  task automatic queue_sample(op_e op, logic [NS-1:0][SB-1:0] raw, int ws, int we);
    sensor_sample_t s;
    s.op = op;
    s.raw = raw;
    s.wstart = WIN_W'(ws);
    s.wend = WIN_W'(we);
    sample_q.push_back(s);
  endtask

  // measure request at the current minima plus the given signal per sensor
  task automatic queue_offsets(int ws, int we, int unsigned d [NS]);
    logic [NS-1:0][SB-1:0] raw;
    int unsigned v;
    for (int i = 0; i < NS; i++) begin
      v = floor_q[i] + d[i];
      raw[i] = (v > SAMPLE_MAX) ? SB'(SAMPLE_MAX) : SB'(v);
    end
    queue_sample(OP_MEAS, raw, ws, we);
  endtask

  // mostly measures near the minima, some calibration sweeps and some pure noise
  task automatic queue_random(int count);
    logic [NS-1:0][SB-1:0] raw;
    int unsigned v, pick, ws, we;
    op_e op;
    repeat (count) begin
      op = ($urandom_range(0, 4) == 0) ? OP_CAL : OP_MEAS;
      for (int i = 0; i < NS; i++) begin
        if (op == OP_CAL) begin
          v = $urandom_range(200, SAMPLE_MAX);
        end else if ($urandom_range(0, 3) == 0) begin
          v = $urandom_range(0, SAMPLE_MAX);
        end else begin
          v = floor_q[i] + $urandom_range(0, 600);
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end
        raw[i] = SB'(v);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        ws = 0;
        we = NS;
      end else if (pick < 8) begin
        ws = $urandom_range(0, NS - 1);
        we = $urandom_range(ws + 1, NS);
      end else begin
        ws = $urandom_range(0, NS);
        we = $urandom_range(0, NS);
      end
      queue_sample(op, raw, ws, we);
    end
  endtask

  task automatic apb_read_check();
    logic [APB_DW-1:0] got;
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    paddr_i <= MIN_TOTAL_ADDR;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do begin
      @(negedge clk_i);
      got = prdata_o;
      @(posedge clk_i);
    end while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    if (got !== APB_DW'(thresh_q)) begin
      n_errors++;
      $display("%0t min_total readback: expected %0d actual %0d", $time, thresh_q, got);
    end
  endtask

  task automatic set_min_total(logic [MIN_TOT_W-1:0] value);
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= MIN_TOTAL_ADDR;
    pwdata_i <= APB_DW'(value);
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    thresh_q = value;
    apb_read_check();
  endtask

  // hold until every queued request has been taken and answered
  task automatic drain();
    while (sample_q.size() != 0 || in_ch.valid || reading_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reading_q.push_back(locate_line(cur_sample));
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_sample = sample_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= cur_sample.op;
          in_ch.raw <= cur_sample.raw;
          in_ch.window_start <= cur_sample.wstart;
          in_ch.window_end <= cur_sample.wend;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          gap_left = in_burst ? 0 : $urandom_range(0, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    line_reading_t want;
    logic [NS-1:0][SB:0] got_cal;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        got_cal = out_ch.cal;
        if (reading_q.size() == 0) begin
          n_errors++;
          $display("%0t result with no request pending: position %0d", $time,
                   out_ch.position);
        end else begin
          want = reading_q.pop_front();
          if (out_ch.position !== want.pos) begin
            n_errors++;
            $display("%0t position: expected %0d actual %0d", $time, want.pos,
                     out_ch.position);
          end
          if (out_ch.line_found !== want.found) begin
            n_errors++;
            $display("%0t line_found: expected %0d actual %0d", $time, want.found,
                     out_ch.line_found);
          end
          for (int i = 0; i < NS; i++) begin
            if (got_cal[i] !== want.cal[i]) begin
              n_errors++;
              $display("%0t cal_%0d: expected %0d actual %0d", $time, i,
                       $signed(want.cal[i]), $signed(got_cal[i]));
            end
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        stall_left = out_burst ? 0 : $urandom_range(0, 14);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= !hold_off && (stall_left == 0);
    end
  end

  // long receiver hold-off mid-run so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    wait (n_taken >= 180);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_400_000;
    $display("%0t timeout: %0d requests taken, %0d results seen", $time, n_taken,
             n_results);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.raw = '0;
    in_ch.window_start = '0;
    in_ch.window_end = '0;
    out_ch.ready = 1'b0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    thresh_q = MIN_TOTAL_RESET;
    for (int i = 0; i < NS; i++) floor_q[i] = SB'(SAMPLE_MAX);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    apb_read_check();

    // reset minima: full-scale and zero readings, then three calibration sweeps
    queue_sample(OP_MEAS, {NS{12'hFFF}}, 0, 5);
    queue_sample(OP_MEAS, '0, 0, 5);
    queue_sample(OP_CAL, {NS{12'hFFF}}, 5, 0);
    queue_sample(OP_CAL, {12'd200, 12'd400, 12'd600, 12'd800, 12'd1000}, 0, 5);
    queue_sample(OP_CAL, {12'd250, 12'd300, 12'd900, 12'd700, 12'd1200}, 2, 4);
    drain();
    queue_offsets(0, 5, '{500, 0, 0, 0, 0});
    queue_offsets(0, 5, '{0, 0, 0, 0, 1000});
    queue_offsets(0, 5, '{100, 100, 100, 100, 100});
    queue_offsets(2, 3, '{100, 100, 100, 100, 100});
    queue_offsets(3, 3, '{300, 300, 300, 300, 300});
    queue_offsets(4, 1, '{300, 300, 300, 300, 300});
    queue_offsets(5, 5, '{300, 300, 300, 300, 300});
    queue_offsets(0, 0, '{300, 300, 300, 300, 300});
    queue_offsets(0, 5, '{0, 100, 200, 0, 0});
    queue_offsets(1, 4, '{300, 300, 300, 300, 300});
    queue_offsets(4, 5, '{0, 0, 0, 0, 250});
    queue_sample(OP_MEAS, {12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0}, 0, 5);
    queue_sample(OP_MEAS, {NS{12'hFFF}}, 1, 4);
    drain();

    // zero threshold: a zero total still finds no line
    set_min_total(16'd0);
    queue_offsets(0, 5, '{0, 0, 0, 0, 0});
    queue_offsets(0, 5, '{0, 0, 1, 0, 0});
    queue_random(95);
    drain();

    // total right at and just under the threshold
    set_min_total(16'd500);
    queue_offsets(0, 5, '{100, 100, 100, 100, 100});
    queue_offsets(0, 5, '{100, 100, 100, 100, 99});
    queue_random(95);
    drain();

    set_min_total(16'hFFFF);
    queue_sample(OP_MEAS, {NS{12'hFFF}}, 0, 5);
    queue_random(30);
    drain();

    set_min_total(16'($urandom_range(1, 3000)));
    queue_random(95);
    drain();

    set_min_total(16'($urandom_range(0, 1200)));
    queue_random(95);
    drain();

    repeat (24) @(posedge clk_i);
    if (reading_q.size() != 0) begin
      n_errors++;
      $display("%0t %0d results never arrived", $time, reading_q.size());
    end
    $display("Covered %0d calibration and %0d measure requests, %0d lines found,",
             n_cal, n_meas, n_found);
    $display("%0d empty windows, %0d negative readings, six min_total settings.",
             n_empty_win, n_negative);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
